### rtl/core/grjm_pkg.sv
// Shared constants, codes and types of the greedy radius jet matcher.
// Used by grjm_dist and greedy_radius_jet_matcher; depends on nothing.
package grjm_pkg;

   // Default sizing
   localparam int MAX_JETS_DEF  = 32;
   localparam int FRAC_BITS_DEF = 12;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int KIND_W   = 2;
   localparam int RAP_W    = 16;
   localparam int AZI_W    = 15;
   localparam int IDX_W    = 5;
   localparam int TOT_W    = 6;
   localparam int RADIUS_W = 32;
   localparam int DIFF_W   = 16;
   localparam int ANG_W    = 17;
   localparam int SQ_W     = 2 * DIFF_W;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'd16777216;

   // pi with 28 fractional bits
   localparam logic [63:0] PI_Q28 = 64'd843314857;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MISS   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FAKE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TOTALS = 2'd3;

   // Steps of the distance unit
   typedef struct packed {
      logic diff_en;   // take differences of query and entry
      logic sq_y_en;   // square rapidity difference
      logic sq_p_en;   // square azimuth difference, keep first square
   } dist_ctrl_type;

   // pi rounded to frac fractional bits
   function automatic logic [ANG_W-1:0] pi_fix(input int frac);
      logic [63:0] v;
      v = (PI_Q28 + (64'd1 << (27 - frac))) >> (28 - frac);
      return v[ANG_W-1:0];
   endfunction

endpackage

### rtl/core/grjm_dist.sv
// Squared distance unit: one shared squarer stepped by the sequencer.
// Depends on grjm_pkg.
module grjm_dist #(
   parameter int FRAC_BITS = grjm_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  grjm_pkg::dist_ctrl_type             ctrl,
   input  logic signed [grjm_pkg::RAP_W-1:0]   query_rap,
   input  logic        [grjm_pkg::AZI_W-1:0]   query_azi,
   input  logic signed [grjm_pkg::RAP_W-1:0]   entry_rap,
   input  logic        [grjm_pkg::AZI_W-1:0]   entry_azi,
   input  logic        [grjm_pkg::RADIUS_W-1:0] radius,
   output logic                                hit
);

   localparam logic [grjm_pkg::ANG_W-1:0] PI_FIX     = grjm_pkg::pi_fix(FRAC_BITS);
   localparam logic [grjm_pkg::ANG_W-1:0] TWO_PI_FIX = PI_FIX << 1;

   logic signed [grjm_pkg::RAP_W:0]   dy;
   logic        [grjm_pkg::RAP_W:0]   ady;
   logic        [grjm_pkg::ANG_W-1:0] dphi0;
   logic        [grjm_pkg::ANG_W-1:0] dphi1;
   logic        [grjm_pkg::ANG_W-1:0] dphi2;
   logic        [grjm_pkg::DIFF_W-1:0] ady_ff;
   logic        [grjm_pkg::DIFF_W-1:0] dphi_ff;
   logic        [grjm_pkg::DIFF_W-1:0] mul_a;
   logic        [grjm_pkg::SQ_W-1:0]   prod;
   logic        [grjm_pkg::SQ_W-1:0]   prod_ff;
   logic        [grjm_pkg::SQ_W-1:0]   acc_ff;
   logic        [grjm_pkg::SQ_W:0]     dist_sq;

   // Rapidity difference magnitude
   always_comb begin
      dy  = {query_rap[grjm_pkg::RAP_W-1], query_rap}
          - {entry_rap[grjm_pkg::RAP_W-1], entry_rap};
      ady = dy[grjm_pkg::RAP_W] ? (grjm_pkg::RAP_W+1)'(-dy) : dy;
   end

   // Azimuth difference, reduced by 2pi and folded into [0, pi]
   always_comb begin
      dphi0 = (query_azi > entry_azi)
            ? grjm_pkg::ANG_W'(query_azi - entry_azi)
            : grjm_pkg::ANG_W'(entry_azi - query_azi);
      dphi1 = (dphi0 >= TWO_PI_FIX) ? dphi0 - TWO_PI_FIX : dphi0;
      dphi2 = (dphi1 > PI_FIX) ? TWO_PI_FIX - dphi1 : dphi1;
   end

   // Shared squarer
   assign mul_a = ctrl.sq_y_en ? ady_ff : dphi_ff;
   assign prod  = mul_a * mul_a;

   always_ff @(posedge clock) begin
      if (ctrl.diff_en) begin
         ady_ff  <= ady[grjm_pkg::DIFF_W-1:0];
         dphi_ff <= dphi2[grjm_pkg::DIFF_W-1:0];
      end
      if (ctrl.sq_y_en || ctrl.sq_p_en) begin
         prod_ff <= prod;
      end
      if (ctrl.sq_p_en) begin
         acc_ff <= prod_ff;
      end
   end

   // Sum of squares against the radius
   assign dist_sq = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign hit     = dist_sq <= (grjm_pkg::SQ_W+1)'(radius);

endmodule

### rtl/core/greedy_radius_jet_matcher.sv
// Top level of the greedy radius jet matcher: sequencer, jet table, result register.
// Depends on grjm_pkg and grjm_dist.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, rapidity, azimuth
//   rsp      out        rsp_valid/rsp_stall  kind, indexes, totals, overflowed, last
//   csr      in         csr_wr_en            radius_squared
//
// A query walks the table in load order and skips taken entries; each untaken
// entry visited is read, differenced, squared in two squarer passes and then
// compared, and reaching the table end reports a miss. A finish visits every
// entry and then emits the totals. Every result word waits in the output
// register until it is taken, and a stalled result stops the sequencer. Reset
// empties the table at once.
module greedy_radius_jet_matcher #(
   parameter int MAX_JETS  = grjm_pkg::MAX_JETS_DEF,
   parameter int FRAC_BITS = grjm_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [grjm_pkg::OP_W-1:0]            req_op,
   input  logic signed [grjm_pkg::RAP_W-1:0]    req_rapidity,
   input  logic [grjm_pkg::AZI_W-1:0]           req_azimuth,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [grjm_pkg::KIND_W-1:0]          rsp_kind,
   output logic [grjm_pkg::IDX_W-1:0]           rsp_truth_index,
   output logic [grjm_pkg::IDX_W-1:0]           rsp_reco_index,
   output logic [grjm_pkg::TOT_W-1:0]           rsp_matched_total,
   output logic [grjm_pkg::TOT_W-1:0]           rsp_missed_total,
   output logic [grjm_pkg::TOT_W-1:0]           rsp_fake_total,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_last,
   input  logic                                 csr_wr_en,
   input  logic [grjm_pkg::RADIUS_W-1:0]        csr_wr_data
);

   localparam int ADDR_W = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
   localparam int CNT_W  = $clog2(MAX_JETS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JETS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_SQY   = 3'd3;
   localparam logic [2:0] ST_SQP   = 3'd4;
   localparam logic [2:0] ST_CMP   = 3'd5;
   localparam logic [2:0] ST_FSCAN = 3'd6;
   localparam logic [2:0] ST_WAIT  = 3'd7;

   // Control state
   logic [2:0]                state_ff,     state_in;
   logic                      ret_fscan_ff, ret_fscan_in;
   logic [CNT_W-1:0]          idx_ff,       idx_in;
   logic [CNT_W-1:0]          stored_ff,    stored_in;
   logic [CNT_W-1:0]          query_ff,     query_in;
   logic [CNT_W-1:0]          pair_ff,      pair_in;
   logic [CNT_W-1:0]          miss_ff,      miss_in;
   logic [CNT_W-1:0]          fake_ff,      fake_in;
   logic                      over_ff,      over_in;
   logic [MAX_JETS-1:0]       taken_ff,     taken_in;
   logic [grjm_pkg::RADIUS_W-1:0] radius_ff;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Payload
   logic signed [grjm_pkg::RAP_W-1:0] q_rap_ff;
   logic [grjm_pkg::AZI_W-1:0]        q_azi_ff;
   logic [grjm_pkg::KIND_W-1:0]       kind_ff,    kind_in;
   logic [grjm_pkg::IDX_W-1:0]        truth_ff,   truth_in;
   logic [grjm_pkg::IDX_W-1:0]        reco_ff,    reco_in;
   logic [grjm_pkg::TOT_W-1:0]        mtot_ff,    mtot_in;
   logic [grjm_pkg::TOT_W-1:0]        xtot_ff,    xtot_in;
   logic [grjm_pkg::TOT_W-1:0]        ftot_ff,    ftot_in;
   logic                              ovf_ff,     ovf_in;
   logic                              last_ff,    last_in;

   // Jet table
   logic signed [grjm_pkg::RAP_W-1:0] mem_rap [MAX_JETS];
   logic [grjm_pkg::AZI_W-1:0]        mem_azi [MAX_JETS];
   logic signed [grjm_pkg::RAP_W-1:0] rd_rap_ff;
   logic [grjm_pkg::AZI_W-1:0]        rd_azi_ff;

   logic                    req_take;
   logic                    rsp_take;
   logic                    wr_en;
   logic                    rd_en;
   logic                    in_range;
   logic                    hit;
   logic                    emit;
   grjm_pkg::dist_ctrl_type dctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign in_range  = (idx_ff < stored_ff);

   assign wr_en = req_take && (req_op == grjm_pkg::OP_LOAD) && (stored_ff < MAX_CNT);
   assign rd_en = (state_ff == ST_SCAN) && in_range && !taken_ff[idx_ff[ADDR_W-1:0]];

   assign dctrl.diff_en = (state_ff == ST_DIFF);
   assign dctrl.sq_y_en = (state_ff == ST_SQY);
   assign dctrl.sq_p_en = (state_ff == ST_SQP);

   grjm_dist #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dist (
      .clock     (clock),
      .ctrl      (dctrl),
      .query_rap (q_rap_ff),
      .query_azi (q_azi_ff),
      .entry_rap (rd_rap_ff),
      .entry_azi (rd_azi_ff),
      .radius    (radius_ff),
      .hit       (hit)
   );

   // Table write on load, registered read during the scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_rap[stored_ff[ADDR_W-1:0]] <= req_rapidity;
         mem_azi[stored_ff[ADDR_W-1:0]] <= req_azimuth;
      end
      if (rd_en) begin
         rd_rap_ff <= mem_rap[idx_ff[ADDR_W-1:0]];
         rd_azi_ff <= mem_azi[idx_ff[ADDR_W-1:0]];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ret_fscan_in = ret_fscan_ff;
      idx_in       = idx_ff;
      stored_in    = stored_ff;
      query_in     = query_ff;
      pair_in      = pair_ff;
      miss_in      = miss_ff;
      fake_in      = fake_ff;
      over_in      = over_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff;
      emit         = 1'b0;
      kind_in      = kind_ff;
      truth_in     = '0;
      reco_in      = '0;
      mtot_in      = '0;
      xtot_in      = '0;
      ftot_in      = '0;
      ovf_in       = 1'b0;
      last_in      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_op)
                  grjm_pkg::OP_LOAD: begin
                     if (stored_ff < MAX_CNT) begin
                        taken_in[stored_ff[ADDR_W-1:0]] = 1'b0;
                        stored_in = stored_ff + 1'b1;
                     end else begin
                        over_in = 1'b1;
                     end
                  end
                  grjm_pkg::OP_QUERY: begin
                     if (query_ff >= MAX_CNT) begin
                        over_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  grjm_pkg::OP_FINISH: begin
                     idx_in   = '0;
                     fake_in  = '0;
                     state_in = ST_FSCAN;
                  end
                  grjm_pkg::OP_UNUSED: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Skip taken entries, read the next candidate, or report a miss
         ST_SCAN: begin
            priority if (!in_range) begin
               emit         = 1'b1;
               kind_in      = grjm_pkg::KIND_MISS;
               truth_in     = grjm_pkg::IDX_W'(query_ff);
               last_in      = 1'b1;
               miss_in      = miss_ff + 1'b1;
               query_in     = query_ff + 1'b1;
               ret_fscan_in = 1'b0;
               state_in     = ST_WAIT;
            end else if (taken_ff[idx_ff[ADDR_W-1:0]]) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_DIFF;
            end
         end

         ST_DIFF: state_in = ST_SQY;
         ST_SQY:  state_in = ST_SQP;
         ST_SQP:  state_in = ST_CMP;

         // Take the entry on a hit, else advance
         ST_CMP: begin
            if (hit) begin
               emit         = 1'b1;
               kind_in      = grjm_pkg::KIND_MATCH;
               truth_in     = grjm_pkg::IDX_W'(query_ff);
               reco_in      = grjm_pkg::IDX_W'(idx_ff);
               last_in      = 1'b1;
               taken_in[idx_ff[ADDR_W-1:0]] = 1'b1;
               pair_in      = pair_ff + 1'b1;
               query_in     = query_ff + 1'b1;
               ret_fscan_in = 1'b0;
               state_in     = ST_WAIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end

         // Emit fakes in load order, then totals, then clear the event
         ST_FSCAN: begin
            priority if (!in_range) begin
               emit         = 1'b1;
               kind_in      = grjm_pkg::KIND_TOTALS;
               mtot_in      = grjm_pkg::TOT_W'(pair_ff);
               xtot_in      = grjm_pkg::TOT_W'(miss_ff);
               ftot_in      = grjm_pkg::TOT_W'(fake_ff);
               ovf_in       = over_ff;
               last_in      = 1'b1;
               taken_in     = '0;
               stored_in    = '0;
               query_in     = '0;
               pair_in      = '0;
               miss_in      = '0;
               over_in      = 1'b0;
               ret_fscan_in = 1'b0;
               state_in     = ST_WAIT;
            end else if (!taken_ff[idx_ff[ADDR_W-1:0]]) begin
               emit         = 1'b1;
               kind_in      = grjm_pkg::KIND_FAKE;
               reco_in      = grjm_pkg::IDX_W'(idx_ff);
               fake_in      = fake_ff + 1'b1;
               idx_in       = idx_ff + 1'b1;
               ret_fscan_in = 1'b1;
               state_in     = ST_WAIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Hold until the result word is taken
         ST_WAIT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               state_in     = ret_fscan_ff ? ST_FSCAN : ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_fscan_ff <= 1'b0;
         idx_ff       <= '0;
         stored_ff    <= '0;
         query_ff     <= '0;
         pair_ff      <= '0;
         miss_ff      <= '0;
         fake_ff      <= '0;
         over_ff      <= 1'b0;
         taken_ff     <= '0;
         radius_ff    <= grjm_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_fscan_ff <= ret_fscan_in;
         idx_ff       <= idx_in;
         stored_ff    <= stored_in;
         query_ff     <= query_in;
         pair_ff      <= pair_in;
         miss_ff      <= miss_in;
         fake_ff      <= fake_in;
         over_ff      <= over_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: capture query coordinates and result fields
   always_ff @(posedge clock) begin
      if (req_take && (req_op == grjm_pkg::OP_QUERY)) begin
         q_rap_ff <= req_rapidity;
         q_azi_ff <= req_azimuth;
      end
      if (emit) begin
         kind_ff  <= kind_in;
         truth_ff <= truth_in;
         reco_ff  <= reco_in;
         mtot_ff  <= mtot_in;
         xtot_ff  <= xtot_in;
         ftot_ff  <= ftot_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_truth_index   = truth_ff;
   assign rsp_reco_index    = reco_ff;
   assign rsp_matched_total = mtot_ff;
   assign rsp_missed_total  = xtot_ff;
   assign rsp_fake_total    = ftot_ff;
   assign rsp_overflowed    = ovf_ff;
   assign rsp_last          = last_ff;

endmodule
